FILE: sv/pcso_pkg.sv
// Shared types, constants and arithmetic helpers for the character stream obfuscator.
package pcso_pkg;

   localparam int unsigned KEY_W = 12;

   localparam logic [12:0] KEY_MOD = 13'd3967;
   localparam logic [12:0] KEY_ADD = 13'd3947;
   localparam logic [7:0]  ALPHA   = 8'd94;

   localparam logic [6:0] CODE_LO   = 7'd32;
   localparam logic [6:0] CODE_GAP  = 7'd92;
   localparam logic [6:0] CODE_HI   = 7'd126;
   localparam logic [6:0] IDX_SPLIT = 7'd59;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_START_KEY = 2'd0;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [7:0]       byte_type;

   typedef struct packed {
      logic advance;
      logic restart;
      logic transform;
   } key_ctrl_type;

   // one conditional subtract, valid for v < 2*KEY_MOD
   function automatic logic [12:0] mod_fold(input logic [12:0] v);
      return (v >= KEY_MOD) ? v - KEY_MOD : v;
   endfunction

   // key*3943 + 3947 mod 3967, using 3943 == -24 mod 3967
   function automatic key_type key_step(input key_type k);
      logic [12:0] r;
      logic [12:0] t;
      r = mod_fold({1'b0, k});
      t = mod_fold({r[11:0], 1'b0});
      t = mod_fold(t + r);
      t = mod_fold({t[11:0], 1'b0});
      t = mod_fold({t[11:0], 1'b0});
      t = mod_fold({t[11:0], 1'b0});
      if (t <= KEY_ADD) begin
         t = KEY_ADD - t;
      end else begin
         t = KEY_ADD + KEY_MOD - t;
      end
      return t[11:0];
   endfunction

   // restoring reduction by 94, key below 94*64
   function automatic logic [6:0] key_mod94(input key_type k);
      logic [11:0] r;
      r = k;
      for (int i = 5; i >= 0; i--) begin
         if (r >= (12'(ALPHA) << i)) begin
            r = r - (12'(ALPHA) << i);
         end
      end
      return r[6:0];
   endfunction

   function automatic logic is_printable(input logic [6:0] c);
      return (c inside {[CODE_LO:CODE_GAP - 7'd1], [CODE_GAP + 7'd1:CODE_HI]});
   endfunction

   function automatic logic [6:0] code_to_index(input logic [6:0] c);
      return (c < CODE_GAP) ? c - CODE_LO : c - CODE_LO - 7'd1;
   endfunction

   function automatic logic [6:0] index_to_code(input logic [6:0] i);
      return (i <= IDX_SPLIT) ? i + CODE_LO : i + CODE_LO + 7'd1;
   endfunction

endpackage

FILE: sv/pcso_req_if.sv
// Input channel: character byte with direction and restart flags.
interface pcso_req_if;
   logic                 valid;
   logic                 ready;
   pcso_pkg::byte_type   in_byte;
   logic                 decrypt;
   logic                 restart;

   modport source(output valid, in_byte, decrypt, restart, input ready);
   modport sink(input valid, in_byte, decrypt, restart, output ready);
endinterface

FILE: sv/pcso_rsp_if.sv
// Result channel: transformed character byte.
interface pcso_rsp_if;
   logic                 valid;
   logic                 ready;
   pcso_pkg::byte_type   out_byte;

   modport source(output valid, out_byte, input ready);
   modport sink(input valid, out_byte, output ready);
endinterface

FILE: sv/pcso_csr.sv
// APB register block holding the start key.
module pcso_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pcso_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output pcso_pkg::key_type                 start_key
);

   pcso_pkg::key_type start_key_ff;
   pcso_pkg::key_type start_key_in;
   logic              wr_en;

   assign wr_en = psel & penable & pwrite & (paddr == pcso_pkg::CSR_ADDR_START_KEY);

   always_comb begin
      start_key_in = start_key_ff;
      if (wr_en) begin
         start_key_in = pwdata[pcso_pkg::KEY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_key_ff <= '0;
      end else begin
         start_key_ff <= start_key_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == pcso_pkg::CSR_ADDR_START_KEY) begin
         prdata = {{(32 - pcso_pkg::KEY_W){1'b0}}, start_key_ff};
      end
   end

   assign pready    = 1'b1;
   assign start_key = start_key_ff;

endmodule

FILE: sv/pcso_key_unit.sv
// Key state register and its combinational recurrence step.
module pcso_key_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  pcso_pkg::key_ctrl_type  ctrl,
   input  pcso_pkg::key_type       start_key,
   output pcso_pkg::key_type       key_new
);

   pcso_pkg::key_type key_ff;
   pcso_pkg::key_type key_in;
   pcso_pkg::key_type key_cur;

   assign key_cur = ctrl.restart ? start_key : key_ff;
   assign key_new = pcso_pkg::key_step(key_cur);

   always_comb begin
      key_in = key_ff;
      if (ctrl.advance) begin
         if (ctrl.transform) begin
            key_in = key_new;
         end else if (ctrl.restart) begin
            key_in = start_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

FILE: sv/pcso_char_map.sv
// Index shift of a printable code by the key, modulo 94.
module pcso_char_map (
   input  pcso_pkg::byte_type  in_byte,
   input  logic                decrypt,
   input  logic                transform,
   input  pcso_pkg::key_type   key,
   output pcso_pkg::byte_type  out_byte
);

   logic [6:0] low;
   logic [6:0] k94;
   logic [6:0] idx;
   logic [7:0] sum;
   logic [7:0] shifted;
   logic [6:0] code;

   always_comb begin
      low = in_byte[6:0];
      k94 = pcso_pkg::key_mod94(key);
      idx = pcso_pkg::code_to_index(low);
      if (decrypt) begin
         sum = {1'b0, idx} + pcso_pkg::ALPHA - {1'b0, k94};
      end else begin
         sum = {1'b0, idx} + {1'b0, k94};
      end
      shifted = (sum >= pcso_pkg::ALPHA) ? sum - pcso_pkg::ALPHA : sum;
      code = transform ? pcso_pkg::index_to_code(shifted[6:0]) : low;
      out_byte = {in_byte[7], code};
   end

endmodule

FILE: sv/printable_char_stream_obfuscator_top.sv
// A req transfer passes through the input (s1), key (s2) and result registers before rsp valid.
// Throughput: one byte per cycle while rsp is not stalled; the key recurrence loops around the key register.
// A stalled rsp holds all stages; req ready follows rsp ready through the result register.
// Reset (synchronous): clears stage valids, the key state and start_key to zero.
module printable_char_stream_obfuscator_top (
   input  logic                              clock,
   input  logic                              reset,
   pcso_req_if.sink                          req_chan,
   pcso_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcso_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic                   adv;
   pcso_pkg::key_type      start_key;
   pcso_pkg::key_type      key_new;
   pcso_pkg::key_ctrl_type key_ctrl;
   pcso_pkg::byte_type     map_byte;
   logic                   s1_transform;

   logic                   s1_valid_ff,     s1_valid_in;
   pcso_pkg::byte_type     s1_byte_ff,      s1_byte_in;
   logic                   s1_decrypt_ff,   s1_decrypt_in;
   logic                   s1_restart_ff,   s1_restart_in;

   logic                   s2_valid_ff,     s2_valid_in;
   pcso_pkg::byte_type     s2_byte_ff,      s2_byte_in;
   logic                   s2_decrypt_ff,   s2_decrypt_in;
   logic                   s2_transform_ff, s2_transform_in;
   pcso_pkg::key_type      s2_key_ff,       s2_key_in;

   logic                   rsp_valid_ff,    rsp_valid_in;
   pcso_pkg::byte_type     rsp_byte_ff,     rsp_byte_in;

   pcso_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .start_key (start_key)
   );

   assign adv            = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = adv;
   assign s1_transform   = pcso_pkg::is_printable(s1_byte_ff[6:0]);

   assign key_ctrl.advance   = adv & s1_valid_ff;
   assign key_ctrl.restart   = s1_restart_ff;
   assign key_ctrl.transform = s1_transform;

   pcso_key_unit u_key (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (key_ctrl),
      .start_key (start_key),
      .key_new   (key_new)
   );

   pcso_char_map u_map (
      .in_byte   (s2_byte_ff),
      .decrypt   (s2_decrypt_ff),
      .transform (s2_transform_ff),
      .key       (s2_key_ff),
      .out_byte  (map_byte)
   );

   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_byte_in      = s1_byte_ff;
      s1_decrypt_in   = s1_decrypt_ff;
      s1_restart_in   = s1_restart_ff;
      s2_valid_in     = s2_valid_ff;
      s2_byte_in      = s2_byte_ff;
      s2_decrypt_in   = s2_decrypt_ff;
      s2_transform_in = s2_transform_ff;
      s2_key_in       = s2_key_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;
      if (adv) begin
         s1_valid_in     = req_chan.valid;
         s1_byte_in      = req_chan.in_byte;
         s1_decrypt_in   = req_chan.decrypt;
         s1_restart_in   = req_chan.restart;
         s2_valid_in     = s1_valid_ff;
         s2_byte_in      = s1_byte_ff;
         s2_decrypt_in   = s1_decrypt_ff;
         s2_transform_in = s1_transform;
         s2_key_in       = key_new;
         rsp_valid_in    = s2_valid_ff;
         rsp_byte_in     = map_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff      <= s1_byte_in;
      s1_decrypt_ff   <= s1_decrypt_in;
      s1_restart_ff   <= s1_restart_in;
      s2_byte_ff      <= s2_byte_in;
      s2_decrypt_ff   <= s2_decrypt_in;
      s2_transform_ff <= s2_transform_in;
      s2_key_ff       <= s2_key_in;
      rsp_byte_ff     <= rsp_byte_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;

   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_valid_ff) |=> s2_valid_ff)
      else $error("stage 1 item lost on advance");

   a_top_bit: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff) |=> (rsp_byte_ff[7] == $past(s2_byte_ff[7])))
      else $error("top bit altered");

   a_passthru: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff && !s2_transform_ff) |=> (rsp_byte_ff == $past(s2_byte_ff)))
      else $error("non-printable byte altered");

   a_printable: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_valid_ff && s2_transform_ff) |=>
         (rsp_byte_ff[6:0] >= 7'd32 && rsp_byte_ff[6:0] <= 7'd126 &&
          rsp_byte_ff[6:0] != 7'd92))
      else $error("transformed byte outside printable set");

endmodule

FILE: tb/printable_char_stream_obfuscator_top_test.sv
// Self-checking testbench for the printable character stream obfuscator top level.
module printable_char_stream_obfuscator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned KEY_MULT      = 3943;
   localparam int unsigned KEY_INC       = 3947;
   localparam int unsigned KEY_MODULUS   = 3967;
   localparam int unsigned ALPHABET_SIZE = 94;
   localparam int unsigned CODE_FIRST    = 32;
   localparam int unsigned CODE_BSLASH   = 92;
   localparam int unsigned CODE_LAST     = 126;
   localparam int unsigned INDEX_SPLIT   = 59;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned DRAIN_CYCLES  = 6;

   typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH, IDLE_HOLD} idle_mode_type;

   typedef struct packed {
      pcso_pkg::byte_type data;
      logic               decrypt;
      logic               restart;
   } char_req_type;

   logic clock;
   logic reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [pcso_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   pcso_req_if req_chan();
   pcso_rsp_if rsp_chan();

   printable_char_stream_obfuscator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   char_req_type       pending_chars[$];
   pcso_pkg::byte_type expected_bytes[$];
   pcso_pkg::key_type  start_key_now;
   pcso_pkg::key_type  stream_key;
   int unsigned        chars_queued;
   int unsigned        chars_accepted;
   int unsigned        mismatch_count;
   int unsigned        src_idle_pct;
   int unsigned        snk_stall_pct;
   int unsigned        hold_req;
   int unsigned        hold_ack;
   int unsigned        hold_left;
   logic               req_taken;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one character step: advance key on printable codes, shift the index mod 94
   function automatic pcso_pkg::byte_type obfuscate_char(inout pcso_pkg::key_type key,
                                                         input pcso_pkg::byte_type b,
                                                         input logic dec);
      int unsigned k;
      int unsigned idx;
      int unsigned low;
      low = {25'd0, b[6:0]};
      if (low != CODE_BSLASH && low >= CODE_FIRST && low <= CODE_LAST) begin
         k = (int'(key) * KEY_MULT + KEY_INC) % KEY_MODULUS;
         key = pcso_pkg::key_type'(k);
         idx = (low < CODE_BSLASH) ? low - CODE_FIRST : low - CODE_FIRST - 1;
         k = k % ALPHABET_SIZE;
         if (dec) begin
            idx = (idx + ALPHABET_SIZE - k) % ALPHABET_SIZE;
         end else begin
            idx = (idx + k) % ALPHABET_SIZE;
         end
         low = (idx <= INDEX_SPLIT) ? idx + CODE_FIRST : idx + CODE_FIRST + 1;
      end
      return {b[7], 7'(low)};
   endfunction

   task automatic push_char(input pcso_pkg::byte_type b, input logic dec, input logic rst);
      pending_chars.push_back('{data: b, decrypt: dec, restart: rst});
      chars_queued++;
   endtask

   function automatic pcso_pkg::byte_type rand_char();
      if ($urandom_range(4) == 0) begin
         return pcso_pkg::byte_type'($urandom_range(255));
      end
      return {1'($urandom_range(1)), 7'($urandom_range(CODE_LAST, CODE_FIRST))};
   endfunction

   // random single bytes and messages that mostly start with a restart, some replayed in the other direction
   task automatic queue_stream(input int unsigned count);
      int unsigned        target;
      int unsigned        len;
      logic               dec;
      logic               rst_first;
      pcso_pkg::key_type  replay_key;
      pcso_pkg::byte_type msg[$];
      target = chars_queued + count;
      while (chars_queued < target) begin
         if ($urandom_range(9) == 0) begin
            push_char(pcso_pkg::byte_type'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(7) == 0);
         end else begin
            len = $urandom_range(24, 1);
            dec = 1'($urandom_range(1));
            rst_first = $urandom_range(9) != 0;
            msg.delete();
            for (int i = 0; i < len; i++) begin
               msg.push_back(rand_char());
               push_char(msg[i], dec, rst_first && i == 0);
            end
            if (rst_first && $urandom_range(2) == 0) begin
               replay_key = start_key_now;
               for (int i = 0; i < len; i++) begin
                  push_char(obfuscate_char(replay_key, msg[i], dec), !dec, i == 0);
               end
            end
         end
      end
   endtask

   task automatic drain_stream();
      while (chars_accepted != chars_queued || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_start_key(input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= pcso_pkg::CSR_ADDR_START_KEY;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      start_key_now = value[pcso_pkg::KEY_W-1:0];
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {{(32-pcso_pkg::KEY_W){1'b0}}, start_key_now}) begin
         $display("%0t start_key readback expected %h actual %h", $time,
                  {{(32-pcso_pkg::KEY_W){1'b0}}, start_key_now}, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      src_idle_pct  = (mode == IDLE_SRC) ? 86 : (mode == IDLE_BOTH) ? 15 : 0;
      snk_stall_pct = (mode == IDLE_SNK) ? 86 : (mode == IDLE_BOTH) ? 15 : 0;
   endtask

   // sender
   always @(negedge clock) begin
      char_req_type next_char;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            next_char = pending_chars.pop_front();
            req_chan.valid   <= 1'b1;
            req_chan.in_byte <= next_char.data;
            req_chan.decrypt <= next_char.decrypt;
            req_chan.restart <= next_char.restart;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_ack != hold_req) begin
         hold_left <= HOLD_CYCLES;
         hold_ack  <= hold_req;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // key tracking on every accepted input transfer
   always @(posedge clock) begin
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         if (req_chan.restart) begin
            stream_key = start_key_now;
         end
         expected_bytes.push_back(obfuscate_char(stream_key, req_chan.in_byte,
                                                 req_chan.decrypt));
         chars_accepted++;
      end
   end

   // result check
   always @(posedge clock) begin
      pcso_pkg::byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t out_byte expected none actual %02h", $time, rsp_chan.out_byte);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want) begin
               $display("%0t out_byte expected %02h actual %02h", $time, want,
                        rsp_chan.out_byte);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("printable_char_stream_obfuscator_top: mismatch");
      $finish;
   end

   initial begin
      pcso_pkg::key_type phase_key[6];
      idle_mode_type     phase_mode[6];
      int unsigned       phase_count[6];
      reset            = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      req_chan.decrypt = 1'b0;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
      start_key_now    = '0;
      stream_key       = '0;
      chars_queued     = 0;
      chars_accepted   = 0;
      mismatch_count   = 0;
      hold_req         = 0;
      hold_ack         = 0;
      hold_left        = 0;
      req_taken        = 1'b0;
      set_idle_mode(IDLE_NONE);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, gap code, non-printables, restarts at reset key
      push_char(8'h20, 1'b0, 1'b0);
      push_char(8'h7E, 1'b0, 1'b0);
      push_char(8'h5C, 1'b0, 1'b0);
      push_char(8'hDC, 1'b1, 1'b0);
      push_char(8'h5B, 1'b1, 1'b0);
      push_char(8'h5D, 1'b0, 1'b0);
      push_char(8'h00, 1'b0, 1'b0);
      push_char(8'h1F, 1'b1, 1'b0);
      push_char(8'h7F, 1'b0, 1'b0);
      push_char(8'h80, 1'b0, 1'b0);
      push_char(8'hFF, 1'b1, 1'b0);
      push_char(8'hA0, 1'b0, 1'b0);
      push_char(8'hFE, 1'b1, 1'b0);
      push_char(8'h0A, 1'b0, 1'b1);
      push_char(8'h41, 1'b0, 1'b0);
      push_char(8'h41, 1'b1, 1'b1);
      drain_stream();
      // out-of-range start keys
      write_start_key(32'd4095);
      push_char(8'h20, 1'b0, 1'b1);
      push_char(8'h7E, 1'b1, 1'b0);
      push_char(8'h0D, 1'b0, 1'b1);
      push_char(8'h30, 1'b0, 1'b0);
      drain_stream();
      write_start_key(32'd3967);
      push_char(8'hC1, 1'b0, 1'b1);
      push_char(8'h61, 1'b1, 1'b0);
      drain_stream();

      phase_key   = '{12'd0, 12'd3966, 12'd4095, pcso_pkg::key_type'($urandom_range(4095)),
                      12'd1, pcso_pkg::key_type'($urandom_range(4095))};
      phase_mode  = '{IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH, IDLE_HOLD, IDLE_NONE};
      phase_count = '{180, 200, 200, 220, 180, 150};
      for (int p = 0; p < 6; p++) begin
         write_start_key({20'd0, phase_key[p]});
         set_idle_mode(phase_mode[p]);
         queue_stream(phase_count[p]);
         if (phase_mode[p] == IDLE_HOLD) begin
            hold_req = hold_req + 1;
         end
         drain_stream();
      end

      if (mismatch_count == 0) begin
         $display("printable_char_stream_obfuscator_top: match");
      end else begin
         $display("printable_char_stream_obfuscator_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/pcso_pkg.sv
sv/pcso_req_if.sv
sv/pcso_rsp_if.sv
sv/pcso_csr.sv
sv/pcso_key_unit.sv
sv/pcso_char_map.sv
sv/printable_char_stream_obfuscator_top.sv
tb/printable_char_stream_obfuscator_top_test.sv
